// ===== hdl/awb_pkg.sv =====
// Shared types and constants for the affine warp block.
package awb_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int COORD_W    = 12;
  localparam int FRAC_W     = 16;
  localparam int WEIGHT_W   = 33;

  localparam logic [CFG_IDX_W-1:0] REG_M0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_M1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_M2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_M3     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_M4     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_M5     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd7;

  localparam logic ACT_WRITE   = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  typedef struct packed {
    logic       action;
    logic [9:0] col;
    logic [9:0] row;
    logic [7:0] in_c0;
    logic [7:0] in_c1;
    logic [7:0] in_c2;
    logic [7:0] in_c3;
  } in_t;

  typedef struct packed {
    logic [7:0] out_c0;
    logic [7:0] out_c1;
    logic [7:0] out_c2;
    logic [7:0] out_c3;
    logic       outside_frame;
  } out_t;

  typedef struct packed {
    logic signed [31:0] m0;
    logic signed [31:0] m1;
    logic signed [31:0] m2;
    logic signed [31:0] m3;
    logic signed [31:0] m4;
    logic signed [31:0] m5;
  } matrix_t;

  typedef struct packed {
    logic [COORD_W-1:0] xa;
    logic [COORD_W-1:0] xb;
    logic [COORD_W-1:0] ya;
    logic [COORD_W-1:0] yb;
    logic [FRAC_W-1:0]  fx;
    logic [FRAC_W-1:0]  fy;
  } coord_t;

endpackage

// ===== hdl/awb_xform.sv =====
// Coordinate pipeline: inverse affine map, floor/fraction split, border clamp.
module awb_xform #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                 clk,
  input  logic                 en_b,
  input  logic                 en_c,
  input  logic                 en_d,
  input  logic [9:0]           col,
  input  logic [9:0]           row,
  input  awb_pkg::matrix_t     mat,
  input  logic [10:0]          frame_width,
  input  logic [10:0]          frame_height,
  output awb_pkg::coord_t      coord
);

  localparam logic [12:0] MW = 13'(MAX_WIDTH);
  localparam logic [12:0] MH = 13'(MAX_HEIGHT);

  logic signed [42:0] px0, px1, py0, py1;
  logic signed [43:0] sx, sy;
  logic signed [28:0] x0, x1, y0, y1;
  logic [12:0]        wlim, hlim, whi, hhi;

  function automatic logic [awb_pkg::COORD_W-1:0] clampc(input logic signed [28:0] v,
                                                        input logic [12:0] hi);
    if (v < 0) begin
      return '0;
    end else if (v > $signed({16'b0, hi})) begin
      return hi[awb_pkg::COORD_W-1:0];
    end else begin
      return v[awb_pkg::COORD_W-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en_b) begin
      px0 <= mat.m0 * $signed({1'b0, col});
      px1 <= mat.m1 * $signed({1'b0, row});
      py0 <= mat.m3 * $signed({1'b0, col});
      py1 <= mat.m4 * $signed({1'b0, row});
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      sx <= 44'(px0) + 44'(px1) + 44'(mat.m2);
      sy <= 44'(py0) + 44'(py1) + 44'(mat.m5);
    end
  end

  always_comb begin
    x0   = 29'($signed(sx[43:16]));
    y0   = 29'($signed(sy[43:16]));
    x1   = x0 + 29'sd1;
    y1   = y0 + 29'sd1;
    wlim = ({2'b0, frame_width} > MW) ? MW : {2'b0, frame_width};
    hlim = ({2'b0, frame_height} > MH) ? MH : {2'b0, frame_height};
    whi  = wlim - 13'd1;
    hhi  = hlim - 13'd1;
  end

  always_ff @(posedge clk) begin
    if (en_d) begin
      coord.xa <= clampc(x0, whi);
      coord.xb <= clampc(x1, whi);
      coord.ya <= clampc(y0, hhi);
      coord.yb <= clampc(y1, hhi);
      coord.fx <= sx[15:0];
      coord.fy <= sy[15:0];
    end
  end

endmodule

// ===== hdl/awb_bank.sv =====
// One parity bank of the frame store: one write port, one registered read port.
module awb_bank #(
  parameter int DW = 32,
  parameter int AW = 18
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/awb_lane.sv =====
// One channel lane: weighted products, sum, round half up, saturate.
module awb_lane (
  input  logic                                 clk,
  input  logic                                 en_f,
  input  logic                                 en_g,
  input  logic [3:0][7:0]                      pix,
  input  logic [3:0][awb_pkg::WEIGHT_W-1:0]    wt,
  output logic [7:0]                           value
);

  logic [40:0] prod [4];
  logic [42:0] sum;
  logic [10:0] upper;

  always_ff @(posedge clk) begin
    if (en_f) begin
      for (int i = 0; i < 4; i++) begin
        prod[i] <= wt[i] * pix[i];
      end
    end
  end

  always_comb begin
    sum   = 43'(prod[0]) + 43'(prod[1]) + 43'(prod[2]) + 43'(prod[3]) + 43'h0_8000_0000;
    upper = sum[42:32];
  end

  always_ff @(posedge clk) begin
    if (en_g) begin
      value <= (upper > 11'd255) ? 8'hFF : upper[7:0];
    end
  end

endmodule

// ===== hdl/affine_warp_bilinear_replicate.sv =====
// Affine warp with bilinear blend and replicated border: top level.
// Takes one item per clock unless the output stalls, writes and requests alike,
// and returns a request's pixel through registered stages A to G; a stalled
// output holds only the full stages behind it, so bubbles in front keep closing.
// The frame store is split into four banks by column and row parity, so the 2x2
// neighborhood of any source position is read together, one read port per bank.
// The store is never cleared; pixels must be written before a request reads them.
module affine_warp_bilinear_replicate #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int CHANNELS   = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  awb_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output awb_pkg::out_t                   out_data,
  input  logic                            cfg_we,
  input  logic [awb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [awb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int DW = 8 * CHANNELS;
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int CW = (XW > 1) ? XW - 1 : 1;
  localparam int RW = (YW > 1) ? YW - 1 : 1;
  localparam int AW = CW + RW;
  localparam int WW = awb_pkg::WEIGHT_W;

  awb_pkg::matrix_t mat;
  logic [10:0]      frame_width;
  logic [10:0]      frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      mat.m0       <= 32'sh0001_0000;
      mat.m1       <= '0;
      mat.m2       <= '0;
      mat.m3       <= '0;
      mat.m4       <= 32'sh0001_0000;
      mat.m5       <= '0;
      frame_width  <= 11'd1024;
      frame_height <= 11'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        awb_pkg::REG_M0:     mat.m0 <= cfg_data;
        awb_pkg::REG_M1:     mat.m1 <= cfg_data;
        awb_pkg::REG_M2:     mat.m2 <= cfg_data;
        awb_pkg::REG_M3:     mat.m3 <= cfg_data;
        awb_pkg::REG_M4:     mat.m4 <= cfg_data;
        awb_pkg::REG_M5:     mat.m5 <= cfg_data;
        awb_pkg::REG_WIDTH:  frame_width <= cfg_data[10:0];
        awb_pkg::REG_HEIGHT: frame_height <= cfg_data[10:0];
        default: begin
        end
      endcase
    end
  end

  // stage valids and ready chain
  logic vA, vB, vC, vD, vE, vF, vG;
  logic rA, rB, rC, rD, rE, rF, rG;

  always_comb begin
    rG = !vG || out_ready;
    rF = !vF || rG;
    rE = !vE || rF;
    rD = !vD || rE;
    rC = !vC || rD;
    rB = !vB || rC;
    rA = !vA || rB;
  end

  assign in_ready  = rA;
  assign out_valid = vG;

  awb_pkg::in_t itemA, itemB, itemC, itemD;
  logic         flagA, flagB, flagC, flagD, flagE, flagF, flagG;

  always_ff @(posedge clk) begin
    if (rst) begin
      vA <= 1'b0;
      vB <= 1'b0;
      vC <= 1'b0;
      vD <= 1'b0;
      vE <= 1'b0;
      vF <= 1'b0;
      vG <= 1'b0;
    end else begin
      if (rA) vA <= in_valid;
      if (rB) vB <= vA;
      if (rC) vC <= vB;
      if (rD) vD <= vC;
      if (rE) vE <= vD && (itemD.action == awb_pkg::ACT_REQUEST);
      if (rF) vF <= vE;
      if (rG) vG <= vF;
    end
  end

  always_ff @(posedge clk) begin
    if (rA) begin
      itemA <= in_data;
      flagA <= (11'(in_data.col) >= frame_width) || (11'(in_data.row) >= frame_height);
    end
    if (rB) begin
      itemB <= itemA;
      flagB <= flagA;
    end
    if (rC) begin
      itemC <= itemB;
      flagC <= flagB;
    end
    if (rD) begin
      itemD <= itemC;
      flagD <= flagC;
    end
    if (rE) flagE <= flagD;
    if (rF) flagF <= flagE;
    if (rG) flagG <= flagF;
  end

  awb_pkg::coord_t coordD;

  awb_xform #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_xform (
    .clk         (clk),
    .en_b        (rB),
    .en_c        (rC),
    .en_d        (rD),
    .col         (itemA.col),
    .row         (itemA.row),
    .mat         (mat),
    .frame_width (frame_width),
    .frame_height(frame_height),
    .coord       (coordD)
  );

  // frame store banks, index {row parity, col parity}
  logic [3:0][7:0] wbytes;
  logic            wr_item;
  logic [AW-1:0]   waddr;
  logic [DW-1:0]   wdata;
  logic [DW-1:0]   rdata [4];
  logic [AW-1:0]   raddr [4];

  always_comb begin
    wbytes  = {itemD.in_c3, itemD.in_c2, itemD.in_c1, itemD.in_c0};
    wdata   = DW'(wbytes);
    waddr   = {RW'(itemD.row >> 1), CW'(itemD.col >> 1)};
    wr_item = vD && rE && (itemD.action == awb_pkg::ACT_WRITE)
              && (13'(itemD.col) < 13'(MAX_WIDTH)) && (13'(itemD.row) < 13'(MAX_HEIGHT));
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic [1:0] BANK = 2'(b);
    logic [awb_pkg::COORD_W-1:0] cx, cy;

    always_comb begin
      cx       = (coordD.xa[0] == BANK[0]) ? coordD.xa : coordD.xb;
      cy       = (coordD.ya[0] == BANK[1]) ? coordD.ya : coordD.yb;
      raddr[b] = {RW'(cy >> 1), CW'(cx >> 1)};
    end

    awb_bank #(
      .DW(DW),
      .AW(AW)
    ) u_bank (
      .clk  (clk),
      .we   (wr_item && (itemD.row[0] == BANK[1]) && (itemD.col[0] == BANK[0])),
      .waddr(waddr),
      .wdata(wdata),
      .re   (rE),
      .raddr(raddr[b]),
      .rdata(rdata[b])
    );
  end

  // weights and neighbor bank selects, registered alongside the read
  logic [16:0]   gx, gy;
  logic [WW-1:0] w00, w01, w10, w11;
  logic [1:0]    sel00, sel01, sel10, sel11;

  always_comb begin
    gx = 17'h1_0000 - {1'b0, coordD.fx};
    gy = 17'h1_0000 - {1'b0, coordD.fy};
  end

  always_ff @(posedge clk) begin
    if (rE) begin
      w00   <= WW'({17'b0, gx} * {17'b0, gy});
      w01   <= WW'({18'b0, coordD.fx} * {17'b0, gy});
      w10   <= WW'({17'b0, gx} * {18'b0, coordD.fy});
      w11   <= WW'({18'b0, coordD.fx} * {18'b0, coordD.fy});
      sel00 <= {coordD.ya[0], coordD.xa[0]};
      sel01 <= {coordD.ya[0], coordD.xb[0]};
      sel10 <= {coordD.yb[0], coordD.xa[0]};
      sel11 <= {coordD.yb[0], coordD.xb[0]};
    end
  end

  logic [DW-1:0] p00, p01, p10, p11;

  always_comb begin
    p00 = rdata[sel00];
    p01 = rdata[sel01];
    p10 = rdata[sel10];
    p11 = rdata[sel11];
  end

  logic [3:0][7:0] chan;

  for (genvar i = 0; i < 4; i++) begin : g_lane
    if (i < CHANNELS) begin : g_on
      awb_lane u_lane (
        .clk  (clk),
        .en_f (rF),
        .en_g (rG),
        .pix  ({p11[8*i +: 8], p10[8*i +: 8], p01[8*i +: 8], p00[8*i +: 8]}),
        .wt   ({w11, w10, w01, w00}),
        .value(chan[i])
      );
    end else begin : g_off
      assign chan[i] = 8'd0;
    end
  end

  // merge lanes into the result item
  always_comb begin
    out_data.out_c0        = flagG ? 8'd0 : chan[0];
    out_data.out_c1        = flagG ? 8'd0 : chan[1];
    out_data.out_c2        = flagG ? 8'd0 : chan[2];
    out_data.out_c3        = flagG ? 8'd0 : chan[3];
    out_data.outside_frame = flagG;
  end

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.outside_frame |->
      out_data.out_c0 == 8'd0 && out_data.out_c1 == 8'd0 &&
      out_data.out_c2 == 8'd0 && out_data.out_c3 == 8'd0)
    else $error("outside item carries data");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    vD && rE && itemD.action == awb_pkg::ACT_WRITE |=> !vE)
    else $error("write item entered the blend stages");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output stage");

endmodule
